// File: design/u8sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and constants of the UTF-8 stream decoder
// Byte class prefixes, decoder state and result beat layouts.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int OFS_FIELD_W = 16;
  localparam int CP_W        = 21;
  localparam int LEN_W       = 3;
  localparam int EXT_W       = (OFFSET_BITS > OFS_FIELD_W) ? OFFSET_BITS : OFS_FIELD_W;

  localparam logic [7:0] LEAD2_PREFIX = 8'b1100_0000;
  localparam logic [7:0] LEAD3_PREFIX = 8'b1110_0000;
  localparam logic [7:0] LEAD4_PREFIX = 8'b1111_0000;
  localparam logic [7:0] CONT_PREFIX  = 8'b1000_0000;
  localparam logic [7:0] LEAD4_MASK   = 8'b1111_1000;
  localparam logic [7:0] LEAD3_MASK   = 8'b1111_0000;
  localparam logic [7:0] LEAD2_MASK   = 8'b1110_0000;
  localparam logic [7:0] CONT_MASK    = 8'b1100_0000;
  localparam logic [7:0] TERM_BYTE    = 8'h00;

  localparam logic KIND_CODE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  typedef struct packed {
    logic [LEN_W-1:0]       expected_length;
    logic [LEN_W-1:0]       bytes_collected;
    logic [CP_W-1:0]        payload_accumulator;
    logic [OFS_FIELD_W-1:0] sequence_start;
    logic [OFFSET_BITS-1:0] byte_position;
    logic                   error_seen;
  } dec_state_t;

  typedef struct packed {
    logic                   result_kind;
    logic [CP_W-1:0]        code_point;
    logic [OFS_FIELD_W-1:0] start_offset;
    logic [LEN_W-1:0]       byte_count;
    logic                   string_valid;
  } dec_result_t;

  // Map a byte position onto the offset field: keep the low bits or zero-extend.
  function automatic logic [OFS_FIELD_W-1:0] ofs_field(input logic [OFFSET_BITS-1:0] pos);
    logic [EXT_W-1:0] wide;
    wide = EXT_W'(pos);
    return wide[OFS_FIELD_W-1:0];
  endfunction

endpackage

// File: design/u8sd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_decode: single-byte decode step
// Classifies one byte against the pending sequence, gives the next state and
// at most one result beat.
// ----------------------------------------------------------------------------
module u8sd_decode (
  input  logic [7:0]           text_byte,
  input  u8sd_pkg::dec_state_t cur,
  output u8sd_pkg::dec_state_t nxt,
  output logic                 emit,
  output u8sd_pkg::dec_result_t res
);
  import u8sd_pkg::*;

  logic                   fresh;
  logic [LEN_W-1:0]       count_inc;
  logic [CP_W-1:0]        acc_shift;

  assign count_inc = cur.bytes_collected + LEN_1;
  assign acc_shift = {cur.payload_accumulator[CP_W-7:0], text_byte[5:0]};

  always_comb begin
    nxt   = cur;
    emit  = 1'b0;
    fresh = 1'b0;
    res   = '0;
    res.result_kind = KIND_CODE;

    if (text_byte == TERM_BYTE) begin
      // End of string: report validity, then start over.
      emit             = 1'b1;
      res.result_kind  = KIND_STATUS;
      res.start_offset = ofs_field(cur.byte_position);
      res.string_valid = ~(cur.error_seen | (cur.expected_length != LEN_NONE));
      nxt              = '0;
    end else begin
      if (cur.expected_length != LEN_NONE) begin
        if ((text_byte & CONT_MASK) == CONT_PREFIX) begin
          nxt.payload_accumulator = acc_shift;
          nxt.bytes_collected     = count_inc;
          if (count_inc >= cur.expected_length) begin
            emit                    = 1'b1;
            res.code_point          = acc_shift;
            res.start_offset        = cur.sequence_start;
            res.byte_count          = cur.expected_length;
            nxt.expected_length     = LEN_NONE;
            nxt.bytes_collected     = LEN_NONE;
            nxt.payload_accumulator = '0;
          end
        end else begin
          // Cut short: drop the sequence and decode this byte afresh.
          nxt.error_seen          = 1'b1;
          nxt.expected_length     = LEN_NONE;
          nxt.bytes_collected     = LEN_NONE;
          nxt.payload_accumulator = '0;
          fresh                   = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end

      if (fresh) begin
        if (!text_byte[7]) begin
          emit             = 1'b1;
          res.code_point   = CP_W'(text_byte);
          res.start_offset = ofs_field(cur.byte_position);
          res.byte_count   = LEN_1;
        end else if ((text_byte & LEAD2_MASK) == LEAD2_PREFIX) begin
          nxt.expected_length     = LEN_2;
          nxt.payload_accumulator = CP_W'(text_byte[4:0]);
          nxt.bytes_collected     = LEN_1;
          nxt.sequence_start      = ofs_field(cur.byte_position);
        end else if ((text_byte & LEAD3_MASK) == LEAD3_PREFIX) begin
          nxt.expected_length     = LEN_3;
          nxt.payload_accumulator = CP_W'(text_byte[3:0]);
          nxt.bytes_collected     = LEN_1;
          nxt.sequence_start      = ofs_field(cur.byte_position);
        end else if ((text_byte & LEAD4_MASK) == LEAD4_PREFIX) begin
          nxt.expected_length     = LEN_4;
          nxt.payload_accumulator = CP_W'(text_byte[2:0]);
          nxt.bytes_collected     = LEN_1;
          nxt.sequence_start      = ofs_field(cur.byte_position);
        end else begin
          nxt.error_seen = 1'b1;
        end
      end

      if (cur.byte_position != POS_MAX) begin
        nxt.byte_position = cur.byte_position + OFFSET_BITS'(1);
      end
    end
  end

endmodule

// File: design/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit: streaming UTF-8 decoder
// Takes one string byte per beat and returns decoded codepoints with their
// offset and length, plus one validity status beat per NUL-terminated string.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | sink      | in_valid/in_stall  | text_byte[7:0]
//  out     | source    | out_valid/out_stall| result_kind, code_point[20:0],
//          |           |                    | start_offset[15:0], byte_count[2:0],
//          |           |                    | string_valid
//
//  Rate: one byte per cycle sustained while out_stall is low; the decode step
//  between the input register and the result register is a single classify-and-shift.
//  Path: an accepted byte waits in the input register, then its beat loads the result register.
//  Reset (rst, synchronous): empties both registers and clears decoder state.
//  Stalls: out_stall holds the result register; in_stall rises only when the
//  input register holds a byte and the result register cannot take a beat.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       text_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             result_kind,
  output logic [u8sd_pkg::CP_W-1:0]        code_point,
  output logic [u8sd_pkg::OFS_FIELD_W-1:0] start_offset,
  output logic [u8sd_pkg::LEN_W-1:0]       byte_count,
  output logic                             string_valid
);
  import u8sd_pkg::*;

  // Input register
  logic       byte_valid;
  logic [7:0] byte_data;

  // Decoder state
  dec_state_t  state;
  dec_state_t  state_next;
  logic        emit;
  dec_result_t res;
  dec_result_t result;

  logic out_free;
  logic in_take;
  logic step;

  // Result register can load when empty or when its beat leaves this cycle.
  assign out_free = ~out_valid | ~out_stall;
  assign step     = byte_valid & out_free;
  assign in_stall = byte_valid & ~out_free;
  assign in_take  = in_valid & ~in_stall;

  u8sd_decode u_decode (
    .text_byte (byte_data),
    .cur       (state),
    .nxt       (state_next),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      out_valid  <= 1'b0;
      state      <= '0;
    end else begin
      // Capture the next byte, or drain the input register once decoded.
      if (in_take) begin
        byte_valid <= 1'b1;
        byte_data  <= text_byte;
      end else if (step) begin
        byte_valid <= 1'b0;
      end

      // Advance the decoder and load the result register together.
      if (step) begin
        state <= state_next;
      end
      if (out_free) begin
        out_valid <= step & emit;
        result    <= res;
      end
    end
  end

  assign result_kind  = result.result_kind;
  assign code_point   = result.code_point;
  assign start_offset = result.start_offset;
  assign byte_count   = result.byte_count;
  assign string_valid = result.string_valid;

  // A pending sequence has its lead counted and is never already complete.
  a_pending_count: assert property (@(posedge clk) disable iff (rst)
    (state.expected_length != LEN_NONE) |->
      (state.bytes_collected != LEN_NONE) &&
      (state.bytes_collected < state.expected_length))
    else $error("pending sequence count out of range");

  // Only multi-byte lengths are ever held pending.
  a_pending_len: assert property (@(posedge clk) disable iff (rst)
    (state.expected_length == LEN_NONE) || (state.expected_length == LEN_2) ||
    (state.expected_length == LEN_3) || (state.expected_length == LEN_4))
    else $error("illegal pending sequence length");

  // A decoded terminator leaves the decoder fully cleared.
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (step && (byte_data == TERM_BYTE)) |=> (state == '0))
    else $error("state not cleared after terminator");

  // Status beats carry no codepoint and no length.
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_STATUS)) |->
      (code_point == '0) && (byte_count == LEN_NONE))
    else $error("malformed status beat");

  // The input side only stalls while a byte waits in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (byte_valid && out_valid && out_stall))
    else $error("input stalled without a waiting byte");

endmodule
